### rtl/core/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int HUE_W    = 13;
   localparam int FRAC_W   = 9;
   localparam int CHAN_W   = 8;
   localparam int SV_W     = 17;
   localparam int Q_ONE    = 256;
   localparam int SECTORS  = 6;
   // quotient of a 13-bit hue by a sector of at least 60 steps
   localparam int QUOT_W   = 8;
   localparam int HUE_RK   = 24;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [FRAC_W-1:0] saturation;
      logic [FRAC_W-1:0] brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

endpackage

### rtl/core/hsvrgb_hue_split.sv
`timescale 1ns / 1ps

module hsvrgb_hue_split import hsvrgb_pkg::*; #(
   parameter int HUE_STEPS_PER_DEGREE = 16
) (
   input  logic                   clock,
   input  logic [HUE_W-1:0]       hue,
   output sector_type             sector,
   output logic [$clog2(60*HUE_STEPS_PER_DEGREE+1)-1:0] ramp
);

   localparam int SECTOR_STEPS = 60 * HUE_STEPS_PER_DEGREE;
   localparam int SW = $clog2(SECTOR_STEPS + 1);
   localparam logic [SW-1:0] P_VAL = SW'(SECTOR_STEPS);
   localparam logic [HUE_W-1:0] P_HUE = HUE_W'(SECTOR_STEPS);
   localparam logic [HUE_RK-1:0] RECIP = HUE_RK'((1 << HUE_RK) / SECTOR_STEPS);

   logic [HUE_W-1:0]         hue1_ff;
   logic [HUE_W+HUE_RK-1:0]  prod1_ff;
   logic [HUE_W+HUE_RK-1:0]  prod1_in;
   logic [QUOT_W-1:0]        quot2_ff;
   logic [QUOT_W-1:0]        quot2_in;
   logic [HUE_W-1:0]         rem2_ff;
   logic [HUE_W-1:0]         rem2_in;
   logic [QUOT_W+SW-1:0]     qp_full;
   sector_type               sector3_ff;
   sector_type               sector3_in;
   logic [SW-1:0]            ramp3_ff;
   logic [SW-1:0]            ramp3_in;
   logic [QUOT_W-1:0]        quot_fix;
   logic [HUE_W-1:0]         rem_fix;
   logic [SW-1:0]            offset;
   logic [QUOT_W+7:0]        q171;
   logic [QUOT_W-1:0]        div6;
   logic [QUOT_W-1:0]        sec_full;

   // reciprocal estimate of hue / sector length, low by at most one
   assign prod1_in = hue * RECIP;

   always_comb begin
      quot2_in = prod1_ff[HUE_RK +: QUOT_W];
      qp_full  = quot2_in * P_VAL;
      rem2_in  = hue1_ff - HUE_W'(qp_full);
   end

   always_comb begin
      if (rem2_ff >= P_HUE) begin
         quot_fix = quot2_ff + 1'b1;
         rem_fix  = rem2_ff - P_HUE;
      end else begin
         quot_fix = quot2_ff;
         rem_fix  = rem2_ff;
      end
      offset   = SW'(rem_fix);
      // quotient mod 6 folds the hue back onto one turn of the circle
      q171     = quot_fix * 8'd171;
      div6     = QUOT_W'(q171 >> 10);
      sec_full = quot_fix - QUOT_W'(div6 * QUOT_W'(SECTORS));
      sector3_in = sector_type'(sec_full[2:0]);
      ramp3_in   = sec_full[0] ? (P_VAL - offset) : offset;
   end

   always_ff @(posedge clock) begin
      hue1_ff    <= hue;
      prod1_ff   <= prod1_in;
      quot2_ff   <= quot2_in;
      rem2_ff    <= rem2_in;
      sector3_ff <= sector3_in;
      ramp3_ff   <= ramp3_in;
   end

   assign sector = sector3_ff;
   assign ramp   = ramp3_ff;

endmodule

### rtl/core/hsvrgb_byte_scale.sv
`timescale 1ns / 1ps

module hsvrgb_byte_scale import hsvrgb_pkg::*; #(
   parameter int HUE_STEPS_PER_DEGREE = 16
) (
   input  logic                clock,
   input  logic [SV_W+$clog2(60*HUE_STEPS_PER_DEGREE+1)-1:0] level,
   output logic [CHAN_W-1:0]   chan
);

   localparam int SECTOR_STEPS = 60 * HUE_STEPS_PER_DEGREE;
   localparam int SW = $clog2(SECTOR_STEPS + 1);
   localparam int CW = SV_W + SW;
   localparam int YW = SW + 9;
   localparam logic [SW-1:0] P_VAL = SW'(SECTOR_STEPS);
   localparam logic [YW-1:0] P_Y   = YW'(SECTOR_STEPS);
   localparam logic [YW-1:0] RECIP = YW'((1 << YW) / SECTOR_STEPS);

   logic [CW+7:0]       scaled;
   logic [YW-1:0]       y5_ff;
   logic [YW-1:0]       y5_in;
   logic [2*YW-1:0]     prod;
   logic [YW-1:0]       y6_ff;
   logic [CHAN_W-1:0]   quot6_ff;
   logic [CHAN_W-1:0]   quot6_in;
   logic [CHAN_W+SW-1:0] qp_full;
   logic [YW-1:0]       rem;
   logic [CHAN_W-1:0]   chan7_ff;
   logic [CHAN_W-1:0]   chan7_in;

   // times 255, then drop the 16 fraction bits of the saturation product
   always_comb begin
      scaled = {level, 8'b0} - (CW+8)'(level);
      y5_in  = scaled[CW+7:16];
   end

   always_comb begin
      prod     = y5_ff * RECIP;
      quot6_in = prod[YW +: CHAN_W];
   end

   always_comb begin
      qp_full  = quot6_ff * P_VAL;
      rem      = y6_ff - YW'(qp_full);
      chan7_in = (rem >= P_Y) ? quot6_ff + 1'b1 : quot6_ff;
   end

   always_ff @(posedge clock) begin
      y5_ff    <= y5_in;
      y6_ff    <= y5_ff;
      quot6_ff <= quot6_in;
      chan7_ff <= chan7_in;
   end

   assign chan = chan7_ff;

endmodule

### rtl/core/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter. One word is taken on every clock cycle: busy is
// always low, and each word gives exactly one RGB word on rsp_valid, in the
// order taken. The pipeline has seven register stages (hue split by reciprocal
// multiply and correction over three, the chroma multipliers in one, and the
// per-channel scale to 0..255 over three).
// The receiver cannot stall the output; there is no internal buffering.
// Hue wraps modulo 360 degrees, saturation and brightness above 1.0 are
// clamped to 1.0, and channels are truncated toward zero.
module hsv_to_rgb_converter import hsvrgb_pkg::*; #(
   parameter int HUE_STEPS_PER_DEGREE = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  hsv_pixel_type req_data,
   output logic          rsp_valid,
   output rgb_pixel_type rsp_data
);

   localparam int SECTOR_STEPS = 60 * HUE_STEPS_PER_DEGREE;
   localparam int SW = $clog2(SECTOR_STEPS + 1);
   localparam int CW = SV_W + SW;
   localparam int DEPTH = 7;
   localparam logic [SW-1:0] P_VAL = SW'(SECTOR_STEPS);
   localparam logic [FRAC_W-1:0] ONE = FRAC_W'(Q_ONE);

   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [FRAC_W-1:0] sat1_ff;
   logic [FRAC_W-1:0] sat1_in;
   logic [FRAC_W-1:0] val1_ff;
   logic [FRAC_W-1:0] val1_in;
   logic [SV_W-1:0]   sv2_ff;
   logic [SV_W-1:0]   sv2_in;
   logic [FRAC_W-1:0] val2_ff;
   logic [SV_W-1:0]   sv3_ff;
   logic [FRAC_W-1:0] val3_ff;
   sector_type        sector3;
   logic [SW-1:0]     ramp3;
   logic [CW-1:0]     chroma4_ff;
   logic [CW-1:0]     chroma4_in;
   logic [CW-1:0]     mix4_ff;
   logic [CW-1:0]     mix4_in;
   logic [CW-1:0]     floor4_ff;
   logic [CW-1:0]     floor4_in;
   logic [SV_W-1:0]   gap;
   sector_type        sector4_ff;
   logic [CW-1:0]     red_lvl;
   logic [CW-1:0]     green_lvl;
   logic [CW-1:0]     blue_lvl;

   assign busy = 1'b0;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], start};
      sat1_in  = (req_data.saturation > ONE) ? ONE : req_data.saturation;
      val1_in  = (req_data.brightness > ONE) ? ONE : req_data.brightness;
      sv2_in   = sat1_ff * val1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   hsvrgb_hue_split #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)
   ) u_hue_split (
      .clock (clock),
      .hue   (req_data.hue),
      .sector(sector3),
      .ramp  (ramp3)
   );

   // all levels in units of one over (65536 * sector length)
   always_comb begin
      gap        = {val3_ff, 8'b0} - sv3_ff;
      chroma4_in = sv3_ff * P_VAL;
      mix4_in    = sv3_ff * ramp3;
      floor4_in  = gap * P_VAL;
   end

   always_ff @(posedge clock) begin
      sat1_ff    <= sat1_in;
      val1_ff    <= val1_in;
      sv2_ff     <= sv2_in;
      val2_ff    <= val1_ff;
      sv3_ff     <= sv2_ff;
      val3_ff    <= val2_ff;
      chroma4_ff <= chroma4_in;
      mix4_ff    <= mix4_in;
      floor4_ff  <= floor4_in;
      sector4_ff <= sector3;
   end

   always_comb begin
      case (sector4_ff)
         SECTOR_RED_YELLOW: begin
            red_lvl = chroma4_ff; green_lvl = mix4_ff;    blue_lvl = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            red_lvl = mix4_ff;    green_lvl = chroma4_ff; blue_lvl = '0;
         end
         SECTOR_GREEN_CYAN: begin
            red_lvl = '0;         green_lvl = chroma4_ff; blue_lvl = mix4_ff;
         end
         SECTOR_CYAN_BLUE: begin
            red_lvl = '0;         green_lvl = mix4_ff;    blue_lvl = chroma4_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_lvl = mix4_ff;    green_lvl = '0;         blue_lvl = chroma4_ff;
         end
         default: begin
            red_lvl = chroma4_ff; green_lvl = '0;         blue_lvl = mix4_ff;
         end
      endcase
      red_lvl   = red_lvl + floor4_ff;
      green_lvl = green_lvl + floor4_ff;
      blue_lvl  = blue_lvl + floor4_ff;
   end

   hsvrgb_byte_scale #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)
   ) u_scale_red (
      .clock(clock),
      .level(red_lvl),
      .chan (rsp_data.red)
   );

   hsvrgb_byte_scale #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)
   ) u_scale_green (
      .clock(clock),
      .level(green_lvl),
      .chan (rsp_data.green)
   );

   hsvrgb_byte_scale #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE)
   ) u_scale_blue (
      .clock(clock),
      .level(blue_lvl),
      .chan (rsp_data.blue)
   );

   assign rsp_valid = valid_ff[DEPTH-1];

endmodule
